// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the sliding window peak rate block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/swpr_pkg.sv -----
// Shared constants, types and helper functions of the sliding window peak rate block.
// No dependencies; used via scoped names by swpr_if, the core, swpr_ctrl and swpr_dpath.
`timescale 1ns / 1ps
`default_nettype none

package swpr_pkg;

   localparam int FIFO_DEPTH    = 1024;
   localparam int TIME_BITS     = 40;
   localparam int SPAN_BITS     = 24;
   localparam int COUNT_BITS    = $clog2(FIFO_DEPTH + 1);
   localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [SPAN_BITS-1:0]    span_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [PTR_BITS-1:0]     ptr_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type REG_WINDOW_SPAN = csr_idx_type'(0);
   localparam count_type   FULL_COUNT      = count_type'(FIFO_DEPTH);

   typedef struct packed {
      logic load;
      logic pop;
      logic push;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_ok;
      logic rsp_free;
   } ctrl_status_type;

   function automatic ptr_type next_slot(input ptr_type p);
      ptr_type result;
      if (p == ptr_type'(FIFO_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = p + ptr_type'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/swpr_if.sv -----
// Valid/ready channel interfaces for event beats and result beats.
// Depends on swpr_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface swpr_req_if;
   logic                valid;
   logic                ready;
   swpr_pkg::time_type  event_time;

   modport source (output valid, output event_time, input ready);
   modport sink   (input valid, input event_time, output ready);
endinterface

interface swpr_rsp_if;
   logic                valid;
   logic                ready;
   swpr_pkg::count_type peak_count;
   swpr_pkg::time_type  peak_start;
   swpr_pkg::time_type  peak_end;
   swpr_pkg::count_type window_fill;
   logic                overflow_drop;

   modport source (output valid, output peak_count, output peak_start, output peak_end,
                   output window_fill, output overflow_drop, input ready);
   modport sink   (input valid, input peak_count, input peak_start, input peak_end,
                   input window_fill, input overflow_drop, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sliding_window_peak_rate_core.sv -----
// Top level of the sliding window peak rate block: controller, datapath and checks.
// Depends on swpr_pkg, swpr_if, swpr_ctrl, swpr_dpath and assert_macros.svh.
//
//   Port      Direction  Beat contents
//   req       in         event_time (40 bits, non-decreasing)
//   rsp       out        peak_count, peak_start, peak_end, window_fill, overflow_drop
//   csr_*     in/out     APB register window_span at byte address 0
//
// An event beat passes through the load, the pop loop, the push and the finish step;
// the pop loop reads one FIFO entry per cycle through the single RAM read port.
// Reset is synchronous and needs no clearing pass; the FIFO RAM data is never used
// outside its fill. The result register holds a beat while rsp is stalled, and a
// new event is taken meanwhile; it waits only to hand over its own result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sliding_window_peak_rate_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   swpr_req_if.sink                                req,
   swpr_rsp_if.source                              rsp,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [swpr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [swpr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [swpr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                    csr_pready
);

   swpr_pkg::ctrl_cmd_type    cmd;
   swpr_pkg::ctrl_status_type status;

   assign csr_pready = 1'b1;

   swpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swpr_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .event_time        (req.event_time),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_peak_count    (rsp.peak_count),
      .rsp_peak_start    (rsp.peak_start),
      .rsp_peak_end      (rsp.peak_end),
      .rsp_window_fill   (rsp.window_fill),
      .rsp_overflow_drop (rsp.overflow_drop)
   );

   `ASSERT_IMPL(a_fill_within_peak, clock, reset, rsp.valid, rsp.window_fill <= rsp.peak_count)
   `ASSERT_IMPL(a_peak_nonzero, clock, reset, rsp.valid, rsp.peak_count != '0)
   `ASSERT_IMPL(a_drop_only_full, clock, reset, rsp.valid && rsp.overflow_drop,
                rsp.window_fill == swpr_pkg::FULL_COUNT)
   `ASSERT_NEXT(a_one_event_at_a_time, clock, reset, req.valid && req.ready, !req.ready)

endmodule

`default_nettype wire

// ----- hw/rtl/swpr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/swpr_ctrl.sv -----
// Controller state machine: accepts an event beat, steps the pop loop, pushes, reports.
// Depends on swpr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module swpr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire swpr_pkg::ctrl_status_type status,
   output swpr_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.pop_ok) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/swpr_dpath.sv -----
// Datapath: timestamp FIFO in RAM, pointers, peak record, span register and result register.
// Depends on swpr_pkg and swpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module swpr_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire swpr_pkg::ctrl_cmd_type                cmd,
   output swpr_pkg::ctrl_status_type                  status,
   input  wire swpr_pkg::time_type                    event_time,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [swpr_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [swpr_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [swpr_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output swpr_pkg::count_type                        rsp_peak_count,
   output swpr_pkg::time_type                         rsp_peak_start,
   output swpr_pkg::time_type                         rsp_peak_end,
   output swpr_pkg::count_type                        rsp_window_fill,
   output logic                                       rsp_overflow_drop
);

   swpr_pkg::span_type    span_ff;
   swpr_pkg::csr_idx_type csr_idx;
   logic                  csr_wr;

   swpr_pkg::time_type  now_ff, limit_ff, head_data, head_time;
   logic                late_ff, dropped_ff, dropped_in, full;
   swpr_pkg::ptr_type   head_ff, head_in, tail_ff, tail_in;
   swpr_pkg::count_type fill_ff, fill_in;
   swpr_pkg::count_type best_count_ff, best_count_in;
   swpr_pkg::time_type  best_start_ff, best_start_in, best_end_ff, best_end_in;
   logic                rsp_valid_ff;
   swpr_pkg::count_type rsp_peak_count_ff, rsp_window_fill_ff;
   swpr_pkg::time_type  rsp_peak_start_ff, rsp_peak_end_ff;
   logic                rsp_overflow_drop_ff;

   assign csr_idx    = csr_paddr[swpr_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_idx == swpr_pkg::REG_WINDOW_SPAN);
   assign csr_prdata = (csr_idx == swpr_pkg::REG_WINDOW_SPAN)
                       ? swpr_pkg::CSR_DATA_BITS'(span_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= '0;
      end else if (csr_wr) begin
         span_ff <= csr_pwdata[swpr_pkg::SPAN_BITS-1:0];
      end
   end

   swpr_ram #(
      .WIDTH (swpr_pkg::TIME_BITS),
      .DEPTH (swpr_pkg::FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data (now_ff),
      .rd_addr (head_in),
      .rd_data (head_data)
   );

   assign full            = (fill_ff == swpr_pkg::FULL_COUNT);
   assign status.pop_ok   = late_ff && (fill_ff != '0) && (head_data < limit_ff);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      if (cmd.load) begin
         dropped_in = 1'b0;
      end
      if (cmd.pop) begin
         head_in = swpr_pkg::next_slot(head_ff);
         fill_in = fill_ff - swpr_pkg::count_type'(1);
      end
      if (cmd.push) begin
         tail_in = swpr_pkg::next_slot(tail_ff);
         if (full) begin
            head_in    = swpr_pkg::next_slot(head_ff);
            dropped_in = 1'b1;
         end else begin
            fill_in = fill_ff + swpr_pkg::count_type'(1);
         end
      end
   end

   // When the window holds only the new event, its slot was written in the same
   // cycle that the read was issued, so the stored time comes from the register.
   assign head_time = (fill_ff == swpr_pkg::count_type'(1)) ? now_ff : head_data;

   always_comb begin
      best_count_in = best_count_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      if (cmd.finish && (fill_ff > best_count_ff)) begin
         best_count_in = fill_ff;
         best_start_in = head_time;
         best_end_in   = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         best_count_ff <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         best_count_ff <= best_count_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         dropped_ff    <= dropped_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff   <= event_time;
         late_ff  <= event_time > swpr_pkg::TIME_BITS'(span_ff);
         limit_ff <= event_time - swpr_pkg::TIME_BITS'(span_ff);
      end
      if (cmd.finish) begin
         rsp_peak_count_ff    <= best_count_in;
         rsp_peak_start_ff    <= best_start_in;
         rsp_peak_end_ff      <= best_end_in;
         rsp_window_fill_ff   <= fill_ff;
         rsp_overflow_drop_ff <= dropped_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_peak_count    = rsp_peak_count_ff;
   assign rsp_peak_start    = rsp_peak_start_ff;
   assign rsp_peak_end      = rsp_peak_end_ff;
   assign rsp_window_fill   = rsp_window_fill_ff;
   assign rsp_overflow_drop = rsp_overflow_drop_ff;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for sliding_window_peak_rate_core: event beats in, peak beats out.
// A built-in window predictor supplies the expected beats; needs swpr_pkg, swpr_if and the RTL.
`timescale 1ns / 1ps

module tb_top;

   import swpr_pkg::*;

   typedef struct packed {
      count_type peak_count;
      time_type  peak_start;
      time_type  peak_end;
      count_type window_fill;
      logic      overflow_drop;
   } peak_result_t;

   localparam csr_idx_type REG_SPARE        = csr_idx_type'(1);
   localparam time_type    TIME_TOP         = '1;
   localparam span_type    SPAN_TOP         = span_type'(8916039);
   localparam time_type    BASE_HEADROOM    = 40'h04_0000_0000;
   localparam int          LONG_HOLD_CYCLES = 200;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          RANDOM_BEATS     = 32;
   localparam int          FILL_BEATS       = 1030;
   localparam int          MAX_REPORTS      = 30;
   localparam int          TIMEOUT_NS       = 5_000_000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   swpr_req_if req_bus ();
   swpr_rsp_if rsp_bus ();

   // Window state as the block should hold it.
   time_type  window_times [FIFO_DEPTH];
   ptr_type   oldest_slot = '0;
   ptr_type   free_slot = '0;
   count_type held_events = '0;
   count_type best_events = '0;
   time_type  best_first = '0;
   time_type  best_last = '0;
   span_type  span_setting = '0;

   peak_result_t pending_peaks [$];
   int unsigned  mismatch_count = 0;
   int unsigned  checked_beats = 0;
   bit           send_idle_enable = 1'b0;
   bit           recv_idle_enable = 1'b0;
   bit           long_hold_request = 1'b0;

   sliding_window_peak_rate_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic peak_result_t advance_window(input time_type now);
      peak_result_t result;
      time_type     limit;
      result.overflow_drop = 1'b0;
      if (now > time_type'(span_setting)) begin
         limit = now - time_type'(span_setting);
         while (held_events != 0 && window_times[oldest_slot] < limit) begin
            oldest_slot = oldest_slot + ptr_type'(1);
            held_events = held_events - count_type'(1);
         end
      end
      if (held_events >= count_type'(FIFO_DEPTH)) begin
         oldest_slot = oldest_slot + ptr_type'(1);
         held_events = held_events - count_type'(1);
         result.overflow_drop = 1'b1;
      end
      window_times[free_slot] = now;
      free_slot = free_slot + ptr_type'(1);
      held_events = held_events + count_type'(1);
      if (held_events > best_events) begin
         best_events = held_events;
         best_first = window_times[oldest_slot];
         best_last = now;
      end
      result.peak_count = best_events;
      result.peak_start = best_first;
      result.peak_end = best_last;
      result.window_fill = held_events;
      return result;
   endfunction

   function automatic time_type random_base();
      time_type base;
      base = time_type'({$urandom(), $urandom()});
      if (base > TIME_TOP - BASE_HEADROOM) begin
         base = base - BASE_HEADROOM;
      end
      return base;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("%0t ns mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         pending_peaks.push_back(advance_window(req_bus.event_time));
      end
   end

   always @(posedge clock) begin : result_checker
      peak_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_peaks.size() == 0) begin
            report_mismatch($sformatf("result beat %0d arrived with none expected",
                                      checked_beats));
         end else begin
            want = pending_peaks.pop_front();
            if (rsp_bus.peak_count !== want.peak_count) begin
               report_mismatch($sformatf("beat %0d peak_count %0d, expected %0d",
                                         checked_beats, rsp_bus.peak_count, want.peak_count));
            end
            if (rsp_bus.peak_start !== want.peak_start) begin
               report_mismatch($sformatf("beat %0d peak_start %0h, expected %0h",
                                         checked_beats, rsp_bus.peak_start, want.peak_start));
            end
            if (rsp_bus.peak_end !== want.peak_end) begin
               report_mismatch($sformatf("beat %0d peak_end %0h, expected %0h",
                                         checked_beats, rsp_bus.peak_end, want.peak_end));
            end
            if (rsp_bus.window_fill !== want.window_fill) begin
               report_mismatch($sformatf("beat %0d window_fill %0d, expected %0d",
                                         checked_beats, rsp_bus.window_fill, want.window_fill));
            end
            if (rsp_bus.overflow_drop !== want.overflow_drop) begin
               report_mismatch($sformatf("beat %0d overflow_drop %0b, expected %0b",
                                         checked_beats, rsp_bus.overflow_drop,
                                         want.overflow_drop));
            end
         end
         checked_beats++;
      end
   end

   initial begin : rsp_ready_driver
      int unsigned gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_request = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (recv_idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** sliding_window_peak_rate_core: FAILED **");
      $finish;
   end

   // Valid stays high after a beat so that back-to-back beats need no second update.
   task automatic send_event(input time_type stamp);
      int unsigned gap;
      if (send_idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.event_time <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type index, input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_WINDOW_SPAN) begin
         span_setting = span_type'(data);
      end
   endtask

   task automatic check_span_readback();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {REG_WINDOW_SPAN, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(span_setting)) begin
         report_mismatch($sformatf("window_span reads %0d, expected %0d",
                                   csr_prdata, span_setting));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_register_access();
      check_span_readback();
      csr_write(REG_SPARE, $urandom());
      check_span_readback();
      csr_write(REG_WINDOW_SPAN, CSR_DATA_BITS'($urandom_range(1, SPAN_TOP)));
      check_span_readback();
      csr_write(REG_WINDOW_SPAN, '0);
      check_span_readback();
   endtask

   // Equal-time groups, a tie with the peak, a step backward, the exact window
   // boundary, and the top of the time range.
   task automatic test_window_edges();
      send_idle_enable = 1'b1;
      recv_idle_enable = 1'b1;
      send_event(time_type'(0));
      send_event(time_type'(0));
      send_event(time_type'(5));
      send_event(time_type'(5));
      send_event(time_type'(5));
      send_event(time_type'(3));
      wait_for_results();
      csr_write(REG_WINDOW_SPAN, CSR_DATA_BITS'(SPAN_TOP));
      check_span_readback();
      send_event(time_type'(4));
      send_event(time_type'(SPAN_TOP) + time_type'(5));
      send_event(time_type'(SPAN_TOP) + time_type'(6));
      send_event(TIME_TOP);
      send_event(TIME_TOP);
      wait_for_results();
      csr_write(REG_SPARE, $urandom());
      send_event(TIME_TOP);
      wait_for_results();
   endtask

   task automatic test_random_windows(input span_type span, input bit long_hold);
      time_type    stamp;
      int unsigned step_top;
      int unsigned pick;
      csr_write(REG_WINDOW_SPAN, CSR_DATA_BITS'(span));
      check_span_readback();
      stamp = random_base();
      step_top = int'(span / 8) + 1;
      long_hold_request = long_hold;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 10 == 0) begin
            send_idle_enable = $urandom_range(0, 2) != 0;
            recv_idle_enable = $urandom_range(0, 2) != 0;
         end
         pick = $urandom_range(0, 15);
         if (pick == 15) begin
            send_event(time_type'({$urandom(), $urandom()}));
         end else begin
            if (pick == 14 && stamp > 64) begin
               stamp = stamp - time_type'($urandom_range(1, 64));
            end else if (pick >= 12) begin
               stamp = stamp + time_type'(span) + time_type'($urandom_range(1, 1000));
            end else if (pick >= 5) begin
               stamp = stamp + time_type'($urandom_range(1, step_top));
            end
            send_event(stamp);
         end
      end
      wait_for_results();
   endtask

   // The window outgrows the FIFO, then one late event empties it in a single pass.
   task automatic test_fifo_overflow();
      time_type stamp;
      send_idle_enable = 1'b0;
      recv_idle_enable = 1'b0;
      csr_write(REG_WINDOW_SPAN, CSR_DATA_BITS'(SPAN_TOP));
      stamp = random_base();
      for (int n = 0; n < FILL_BEATS; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            stamp = stamp + time_type'($urandom_range(1, 3));
         end
         send_event(stamp);
      end
      stamp = stamp + time_type'(SPAN_TOP) + time_type'($urandom_range(1, 1000));
      send_event(stamp);
      send_event(stamp);
      send_event(stamp + time_type'($urandom_range(0, 9)));
      wait_for_results();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.event_time = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_window_edges();
      test_random_windows('0, 1'b0);
      test_random_windows(span_type'($urandom_range(1, 4000)), 1'b1);
      test_random_windows(SPAN_TOP, 1'b0);
      test_random_windows(span_type'($urandom_range(0, SPAN_TOP)), 1'b0);
      test_fifo_overflow();
      if (mismatch_count == 0) begin
         $display("** sliding_window_peak_rate_core: PASSED **");
      end else begin
         $display("** sliding_window_peak_rate_core: FAILED **");
      end
      $finish;
   end

endmodule
